@@ src/sml_pkg.sv @@
// ----------------------------------------------------------------------------
// sml_pkg
// shared types and constants for the sorted magnitude list
// ----------------------------------------------------------------------------
package sml_pkg;

  localparam int REQ_W    = 2;
  localparam int ID_W     = 10;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

@@ src/sorted_magnitude_list.sv @@
// ----------------------------------------------------------------------------
// sorted_magnitude_list
// ordered list of item ids: insert places by decreasing key magnitude, push at the front, in one memory
// ----------------------------------------------------------------------------
// usage
//   a request word (req type, item id, Q16.16 key) is taken when start is
//   high and busy is low. every request gives exactly one result word:
//   status, entry count, empty flag and front id, shown for one cycle with
//   out_valid high. the receiver cannot stall, so results never back up.
// timing
//   the list lives in a single-port-read, single-port-write memory with a
//   registered read. one read and at most one write happen per cycle under
//   a small sequencer: a scan pass reads every held entry (id match and
//   sorted place), then, unless the request fails, a move pass shifts the
//   entries between the place (or the deleted entry) and the rear. a clear
//   skips both passes. busy stays high from the accepted request word until
//   the result word is ready; the result word is shown in the first cycle
//   with busy low, and a new request word may be taken in that cycle.
// reset
//   rst_n clears the sequencer, the entry count and the result strobe. the
//   memory is not cleared: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_magnitude_list #(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request word
  input  logic                          start,
  output logic                          busy,
  input  logic [sml_pkg::REQ_W-1:0]     in_req_type,
  input  logic [sml_pkg::ID_W-1:0]      in_item_id,
  input  logic signed [sml_pkg::KEY_W-1:0] in_item_key,
  // result word
  output logic                          out_valid,
  output logic [sml_pkg::STATUS_W-1:0]  out_status,
  output logic [sml_pkg::COUNT_W-1:0]   out_entry_count,
  output logic                          out_is_empty,
  output logic [sml_pkg::ID_W-1:0]      out_front_id
);

  import sml_pkg::*;

  localparam int IW = $clog2(DEPTH);      // memory address bits
  localparam int CW = $clog2(DEPTH + 1);  // count bits, holds DEPTH itself

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [KEY_W-1:0]   mag;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MV_DN,
    S_MV_UP,
    S_DONE
  } state_t;

  // slot memory: ids and magnitudes in list order
  slot_t mem [DEPTH];
  slot_t rdata_r;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic [IW-1:0] mem_raddr;

  // sequencer state
  state_t             state_r, state_nxt;
  req_t               req_r, req_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [KEY_W-1:0]   mag_r, mag_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [ID_BITS-1:0] front_r, front_nxt;
  status_t            status_r, status_nxt;

  // scan and move bookkeeping
  logic [CW-1:0]      idx_r, idx_nxt;       // next read address
  logic [CW-1:0]      idx_dec;              // one below the read address
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      match_pos_r, match_pos_nxt;
  logic               ins_seen_r, ins_seen_nxt;
  logic [CW-1:0]      ins_pos_r, ins_pos_nxt;
  logic [CW-1:0]      tgt_r, tgt_nxt;       // place of the new entry
  logic               wv_r, wv_nxt;         // shifted entry waiting to be written
  logic [CW-1:0]      wdst_r, wdst_nxt;

  // result registers
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [ID_W-1:0]      out_front_r, out_front_nxt;

  logic [KEY_W-1:0] key_u;
  logic [KEY_W-1:0] key_mag;

  assign key_u   = in_item_key;
  // |key| as unsigned, so the most negative key maps to 2^31
  assign key_mag = key_u[KEY_W-1] ? (~key_u + KEY_W'(1)) : key_u;

  assign idx_dec = idx_r - CW'(1);

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    id_nxt        = id_r;
    mag_nxt       = mag_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    match_pos_nxt = match_pos_r;
    ins_seen_nxt  = ins_seen_r;
    ins_pos_nxt   = ins_pos_r;
    tgt_nxt       = tgt_r;
    wv_nxt        = 1'b0;
    wdst_nxt      = wdst_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_front_nxt  = out_front_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata_r;
    mem_raddr = idx_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt      = req_t'(in_req_type);
          id_nxt       = ID_BITS'(in_item_id);
          mag_nxt      = key_mag;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          ins_seen_nxt = 1'b0;
          ins_pos_nxt  = count_r;
          status_nxt   = ST_OK;
          if (req_t'(in_req_type) == REQ_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // read every held entry: look for the id and the sorted place
      S_SCAN: begin
        if (idx_r < count_r) begin
          mem_raddr   = idx_r[IW-1:0];
          idx_nxt     = idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
        end
        if (cmp_vld_r) begin
          if (!found_r && rdata_r.id == id_r) begin
            found_nxt     = 1'b1;
            match_pos_nxt = cmp_idx_r;
          end
          // first entry whose magnitude is not greater
          if (!ins_seen_r && rdata_r.mag <= mag_r) begin
            ins_seen_nxt = 1'b1;
            ins_pos_nxt  = cmp_idx_r;
          end
        end
        if (idx_r >= count_r && !cmp_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (req_r) inside
          REQ_PUSH, REQ_INSERT: begin
            if (found_r) begin
              status_nxt = ST_PRESENT;
              state_nxt  = S_DONE;
            end else if (count_r >= CW'(DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              tgt_nxt   = (req_r == REQ_PUSH) ? '0 : ins_pos_r;
              idx_nxt   = count_r;
              state_nxt = S_MV_DN;
            end
          end
          REQ_DELETE: begin
            if (!found_r) begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_DONE;
            end else begin
              idx_nxt   = match_pos_r + CW'(1);
              state_nxt = S_MV_UP;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // open a gap at tgt: entry i-1 moves to i, rear first
      S_MV_DN: begin
        if (idx_r > tgt_r) begin
          mem_raddr = idx_dec[IW-1:0];
          idx_nxt   = idx_dec;
          wv_nxt    = 1'b1;
          wdst_nxt  = idx_r;
        end
        if (wv_r) begin
          mem_we    = 1'b1;
          mem_waddr = wdst_r[IW-1:0];
          mem_wdata = rdata_r;
        end else if (idx_r == tgt_r) begin
          // gap is open, place the new entry
          mem_we        = 1'b1;
          mem_waddr     = tgt_r[IW-1:0];
          mem_wdata.id  = id_r;
          mem_wdata.mag = mag_r;
          count_nxt     = count_r + CW'(1);
          state_nxt     = S_DONE;
        end
      end

      // close the hole: entry i moves to i-1, front first
      S_MV_UP: begin
        if (idx_r < count_r) begin
          mem_raddr = idx_r[IW-1:0];
          idx_nxt   = idx_r + CW'(1);
          wv_nxt    = 1'b1;
          wdst_nxt  = idx_r - CW'(1);
        end
        if (wv_r) begin
          mem_we    = 1'b1;
          mem_waddr = wdst_r[IW-1:0];
          mem_wdata = rdata_r;
        end
        if (idx_r >= count_r && !wv_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_count_nxt  = COUNT_W'(count_r);
        out_empty_nxt  = (count_r == '0);
        out_front_nxt  = (count_r == '0) ? '0 : ID_W'(front_r);
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // the front id is mirrored from every write to slot zero
    if (mem_we && mem_waddr == '0) begin
      front_nxt = mem_wdata.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      wv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      wv_r        <= wv_nxt;
    end
    req_r        <= req_nxt;
    id_r         <= id_nxt;
    mag_r        <= mag_nxt;
    front_r      <= front_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    match_pos_r  <= match_pos_nxt;
    ins_seen_r   <= ins_seen_nxt;
    ins_pos_r    <= ins_pos_nxt;
    tgt_r        <= tgt_nxt;
    wdst_r       <= wdst_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_front_r  <= out_front_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_front_id    = out_front_r;

endmodule
